// ===== hdl/qsd_pkg.sv =====
`default_nettype none

package qsd_pkg;

  // op queue between the byte parser and the pixel engine
  localparam int unsigned OpQueueDepth = 2;

  // recent-color table
  localparam int unsigned TableDepth = 64;
  localparam int unsigned TableAw    = $clog2(TableDepth);

  // opcode bytes and two-bit tags
  localparam logic [7:0] OPC_RGB   = 8'hfe;
  localparam logic [7:0] OPC_RGBA  = 8'hff;
  localparam logic [1:0] TAG_INDEX = 2'b00;
  localparam logic [1:0] TAG_DIFF  = 2'b01;
  localparam logic [1:0] TAG_LUMA  = 2'b10;
  localparam logic [1:0] TAG_RUN   = 2'b11;

  // delta biases
  localparam logic [7:0] DIFF_BIAS    = 8'd2;
  localparam logic [7:0] LUMA_G_BIAS  = 8'd32;
  localparam logic [7:0] LUMA_RB_BIAS = 8'd8;

  typedef enum logic [2:0] {
    OP_INDEX,
    OP_DIFF,
    OP_LUMA,
    OP_RUN,
    OP_RGB,
    OP_RGBA
  } op_kind_e;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
  } pixel_t;

  // one complete op: arg is the opcode byte (for luma only its low six bits), arg2 the second luma byte
  typedef struct packed {
    op_kind_e   kind;
    logic [7:0] arg;
    logic [7:0] arg2;
    pixel_t     lit;
  } op_t;

  localparam pixel_t PIXEL_RESET = '{r: 8'h00, g: 8'h00, b: 8'h00, a: 8'hff};

  // table slot: (3r + 5g + 7b + 11a) mod 64, only low bits matter
  function automatic logic [TableAw-1:0] qsd_hash(input pixel_t p);
    logic [TableAw-1:0] h;
    h = TableAw'(TableAw'(3) * p.r[TableAw-1:0])
      + TableAw'(TableAw'(5) * p.g[TableAw-1:0])
      + TableAw'(TableAw'(7) * p.b[TableAw-1:0])
      + TableAw'(TableAw'(11) * p.a[TableAw-1:0]);
    return h;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/qsd_front.sv =====
`default_nettype none

module qsd_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire logic [7:0]    code_byte_i,
  output logic               full_o,
  output logic               q_push_o,
  output qsd_pkg::op_t       q_op_o,
  input  wire logic          q_full_i
);

  typedef enum logic [3:0] {
    PH_OPCODE,
    PH_RGB_R,
    PH_RGB_G,
    PH_RGB_B,
    PH_RGBA_R,
    PH_RGBA_G,
    PH_RGBA_B,
    PH_RGBA_A,
    PH_LUMA
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [7:0]  lit_r_q, lit_r_d;
  logic [7:0]  lit_g_q, lit_g_d;
  logic [7:0]  lit_b_q, lit_b_d;
  logic [5:0]  luma_q, luma_d;
  logic        accept;

  // hold bytes off while the op queue has no room
  assign full_o = q_full_i;
  assign accept = push_i && !q_full_i;

  // byte classification and op assembly
  always_comb begin
    phase_d  = phase_q;
    lit_r_d  = lit_r_q;
    lit_g_d  = lit_g_q;
    lit_b_d  = lit_b_q;
    luma_d   = luma_q;
    q_push_o = 1'b0;
    q_op_o   = '{kind: qsd_pkg::OP_INDEX, arg: code_byte_i, arg2: 8'h00, lit: '0};
    if (accept) begin
      unique case (phase_q)
        PH_RGB_R: begin
          lit_r_d = code_byte_i;
          phase_d = PH_RGB_G;
        end
        PH_RGB_G: begin
          lit_g_d = code_byte_i;
          phase_d = PH_RGB_B;
        end
        PH_RGB_B: begin
          q_push_o    = 1'b1;
          q_op_o.kind = qsd_pkg::OP_RGB;
          q_op_o.lit  = '{r: lit_r_q, g: lit_g_q, b: code_byte_i, a: 8'h00};
          phase_d     = PH_OPCODE;
        end
        PH_RGBA_R: begin
          lit_r_d = code_byte_i;
          phase_d = PH_RGBA_G;
        end
        PH_RGBA_G: begin
          lit_g_d = code_byte_i;
          phase_d = PH_RGBA_B;
        end
        PH_RGBA_B: begin
          lit_b_d = code_byte_i;
          phase_d = PH_RGBA_A;
        end
        PH_RGBA_A: begin
          q_push_o    = 1'b1;
          q_op_o.kind = qsd_pkg::OP_RGBA;
          q_op_o.lit  = '{r: lit_r_q, g: lit_g_q, b: lit_b_q, a: code_byte_i};
          phase_d     = PH_OPCODE;
        end
        PH_LUMA: begin
          q_push_o    = 1'b1;
          q_op_o.kind = qsd_pkg::OP_LUMA;
          q_op_o.arg  = {2'b00, luma_q};
          q_op_o.arg2 = code_byte_i;
          phase_d     = PH_OPCODE;
        end
        PH_OPCODE: begin
          priority if (code_byte_i == qsd_pkg::OPC_RGB) begin
            phase_d = PH_RGB_R;
          end else if (code_byte_i == qsd_pkg::OPC_RGBA) begin
            phase_d = PH_RGBA_R;
          end else begin
            unique case (code_byte_i[7:6])
              qsd_pkg::TAG_INDEX: begin
                q_push_o    = 1'b1;
                q_op_o.kind = qsd_pkg::OP_INDEX;
              end
              qsd_pkg::TAG_DIFF: begin
                q_push_o    = 1'b1;
                q_op_o.kind = qsd_pkg::OP_DIFF;
              end
              qsd_pkg::TAG_LUMA: begin
                luma_d  = code_byte_i[5:0];
                phase_d = PH_LUMA;
              end
              qsd_pkg::TAG_RUN: begin
                q_push_o    = 1'b1;
                q_op_o.kind = qsd_pkg::OP_RUN;
              end
              default: begin
                phase_d = PH_OPCODE;
              end
            endcase
          end
        end
        default: begin
          phase_d = PH_OPCODE;
        end
      endcase
    end
  end

  // parse phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_OPCODE;
    end else begin
      phase_q <= phase_d;
    end
  end

  // partial op bytes
  always_ff @(posedge clk_i) begin
    lit_r_q <= lit_r_d;
    lit_g_q <= lit_g_d;
    lit_b_q <= lit_b_d;
    luma_q  <= luma_d;
  end

endmodule

`default_nettype wire

// ===== hdl/qsd_fifo.sv =====
`default_nettype none

module qsd_fifo #(
  parameter int unsigned Depth = qsd_pkg::OpQueueDepth
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  qsd_pkg::op_t       op_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output qsd_pkg::op_t       op_o,
  output logic               empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  qsd_pkg::op_t    mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q;
  logic [PtrW-1:0] rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push;
  logic            do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign op_o    = mem_q[rd_ptr_q];

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= op_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/qsd_back.sv =====
`default_nettype none

module qsd_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  qsd_pkg::op_t       q_op_i,
  input  wire logic          q_empty_i,
  output logic               q_pop_o,
  input  wire logic          pop_i,
  output logic               empty_o,
  output logic [7:0]         red_o,
  output logic [7:0]         green_o,
  output logic [7:0]         blue_o,
  output logic [7:0]         alpha_o,
  output logic               last_of_run_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_EMIT
  } state_e;

  state_e                         state_q;
  qsd_pkg::pixel_t                cur_q;
  logic [5:0]                     remain_q;
  logic                           out_valid_q;
  qsd_pkg::pixel_t                out_pix_q;
  logic                           out_last_q;

  qsd_pkg::pixel_t                tab_q [qsd_pkg::TableDepth];
  logic [qsd_pkg::TableDepth-1:0] tab_vld_q;
  qsd_pkg::pixel_t                rd_pix_q;
  logic                           rd_vld_q;
  logic [qsd_pkg::TableAw-1:0]    rd_addr;
  logic [qsd_pkg::TableAw-1:0]    wr_addr;
  logic                           tab_we;

  qsd_pkg::pixel_t                diff_pix;
  qsd_pkg::pixel_t                luma_pix;
  logic [7:0]                     luma_vg;
  logic                           slot_free;
  logic                           emit_now;

  assign q_pop_o   = (state_q == S_IDLE) && !q_empty_i;
  assign slot_free = !out_valid_q || pop_i;
  assign emit_now  = (state_q == S_EMIT) && slot_free;
  assign rd_addr   = q_op_i.arg[qsd_pkg::TableAw-1:0];
  assign wr_addr   = qsd_pkg::qsd_hash(cur_q);
  assign tab_we    = (state_q == S_EMIT);

  // small-delta update
  always_comb begin
    diff_pix   = cur_q;
    diff_pix.r = cur_q.r + {6'b0, q_op_i.arg[5:4]} - qsd_pkg::DIFF_BIAS;
    diff_pix.g = cur_q.g + {6'b0, q_op_i.arg[3:2]} - qsd_pkg::DIFF_BIAS;
    diff_pix.b = cur_q.b + {6'b0, q_op_i.arg[1:0]} - qsd_pkg::DIFF_BIAS;
  end

  // green-relative update
  always_comb begin
    luma_vg    = {2'b00, q_op_i.arg[5:0]} - qsd_pkg::LUMA_G_BIAS;
    luma_pix   = cur_q;
    luma_pix.r = cur_q.r + luma_vg + {4'b0, q_op_i.arg2[7:4]} - qsd_pkg::LUMA_RB_BIAS;
    luma_pix.g = cur_q.g + luma_vg;
    luma_pix.b = cur_q.b + luma_vg + {4'b0, q_op_i.arg2[3:0]} - qsd_pkg::LUMA_RB_BIAS;
  end

  // recent-color table, registered read
  always_ff @(posedge clk_i) begin
    if (tab_we) begin
      tab_q[wr_addr] <= cur_q;
    end
    rd_pix_q <= tab_q[rd_addr];
    rd_vld_q <= tab_vld_q[rd_addr];
  end

  // entry valid bits, unwritten entries read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tab_vld_q <= '0;
    end else if (tab_we) begin
      tab_vld_q[wr_addr] <= 1'b1;
    end
  end

  // op sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cur_q       <= qsd_pkg::PIXEL_RESET;
      remain_q    <= '0;
      out_valid_q <= 1'b0;
      out_pix_q   <= '0;
      out_last_q  <= 1'b0;
    end else begin
      if (emit_now) begin
        out_valid_q <= 1'b1;
      end else if (pop_i && out_valid_q) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (!q_empty_i) begin
            remain_q <= (q_op_i.kind == qsd_pkg::OP_RUN) ? q_op_i.arg[5:0] : '0;
            unique case (q_op_i.kind)
              qsd_pkg::OP_INDEX: begin
                state_q <= S_READ;
              end
              qsd_pkg::OP_DIFF: begin
                cur_q   <= diff_pix;
                state_q <= S_EMIT;
              end
              qsd_pkg::OP_LUMA: begin
                cur_q   <= luma_pix;
                state_q <= S_EMIT;
              end
              qsd_pkg::OP_RUN: begin
                state_q <= S_EMIT;
              end
              qsd_pkg::OP_RGB: begin
                cur_q.r <= q_op_i.lit.r;
                cur_q.g <= q_op_i.lit.g;
                cur_q.b <= q_op_i.lit.b;
                state_q <= S_EMIT;
              end
              qsd_pkg::OP_RGBA: begin
                cur_q   <= q_op_i.lit;
                state_q <= S_EMIT;
              end
              default: begin
                state_q <= S_IDLE;
              end
            endcase
          end
        end
        S_READ: begin
          cur_q   <= rd_vld_q ? rd_pix_q : '0;
          state_q <= S_EMIT;
        end
        S_EMIT: begin
          if (slot_free) begin
            out_pix_q  <= cur_q;
            out_last_q <= (remain_q == '0);
            if (remain_q == '0) begin
              state_q <= S_IDLE;
            end else begin
              remain_q <= remain_q - 6'd1;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign empty_o       = !out_valid_q;
  assign red_o         = out_pix_q.r;
  assign green_o       = out_pix_q.g;
  assign blue_o        = out_pix_q.b;
  assign alpha_o       = out_pix_q.a;
  assign last_of_run_o = out_last_q;

endmodule

`default_nettype wire

// ===== hdl/qoi_stream_decoder_top.sv =====
// QOI op-stream decoder. Bytes enter through a queue-style port (push/full) and decoded
// pixels leave through another (empty/pop); a pixel sits on the result ports while empty
// is low. A byte parser takes one byte per cycle while the op queue has room, assembles
// multi-byte ops and hands whole ops to a queue of OpQueueDepth entries; a pixel engine
// drains that queue, one op at a time. In the engine a diff, luma, RGB or RGBA op goes from
// idle straight to emit, an index op passes through a read state for the registered read of
// the 64-entry color table, and a run emits its n pixels one per cycle into the output
// register while that register is free. The engine's op rate sets the sustained byte rate
// for single-byte ops; during runs the full signal holds the byte source back. The current
// pixel resets to opaque black and the color table reads as zero until written.
`default_nettype none

module qoi_stream_decoder_top #(
  parameter int unsigned OpQueueDepth = qsd_pkg::OpQueueDepth
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] code_byte_i,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      red_o,
  output logic [7:0]      green_o,
  output logic [7:0]      blue_o,
  output logic [7:0]      alpha_o,
  output logic            last_of_run_o
);

  qsd_pkg::op_t push_op;
  qsd_pkg::op_t head_op;
  logic         q_push;
  logic         q_full;
  logic         q_pop;
  logic         q_empty;

  // byte parser
  qsd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .code_byte_i (code_byte_i),
    .full_o      (full),
    .q_push_o    (q_push),
    .q_op_o      (push_op),
    .q_full_i    (q_full)
  );

  // op queue
  qsd_fifo #(
    .Depth (OpQueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .op_i    (push_op),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .op_o    (head_op),
    .empty_o (q_empty)
  );

  // pixel engine
  qsd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_op_i        (head_op),
    .q_empty_i     (q_empty),
    .q_pop_o       (q_pop),
    .pop_i         (pop),
    .empty_o       (empty),
    .red_o         (red_o),
    .green_o       (green_o),
    .blue_o        (blue_o),
    .alpha_o       (alpha_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

`default_nettype wire

// ===== hdl/qsd_checker.sv =====
`default_nettype none

module qsd_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       empty,
  input wire logic       pop,
  input wire logic [7:0] red_o,
  input wire logic [7:0] green_o,
  input wire logic [7:0] blue_o,
  input wire logic [7:0] alpha_o,
  input wire logic       last_of_run_o
);

  // nothing to take once reset has been seen at an edge
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |=> empty)
    else $error("result visible during reset");

  // a waiting result holds until its transfer
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(red_o) && $stable(green_o)
                          && $stable(blue_o) && $stable(alpha_o) && $stable(last_of_run_o)))
    else $error("waiting result changed before transfer");

  // within a run the next pixel repeats the color
  a_run_repeats: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && !last_of_run_o) |=>
      (empty || (red_o == $past(red_o) && green_o == $past(green_o)
                 && blue_o == $past(blue_o) && alpha_o == $past(alpha_o))))
    else $error("run pixel differs from previous pixel");

  // a run keeps the result side busy right after a non-final transfer
  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && !last_of_run_o) |=> !empty)
    else $error("run broke off before its last pixel");

endmodule

bind qoi_stream_decoder_top qsd_checker u_qsd_checker (.*);

`default_nettype wire
